// ===== hw/rtl/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg: shared types and constants of the triangle face normal pipeline
// Payload structs of both channels, stage bundles and fixed-point widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

   localparam int COORD_W   = 16;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int CROSS_W   = PROD_W + 1;
   localparam int MAG_W     = CROSS_W - 1;
   localparam int POS_W     = $clog2(MAG_W);
   localparam int NORM_W    = 24;
   localparam int NORM_MSB  = NORM_W - 1;
   localparam int SQ_W      = 2 * NORM_W;
   localparam int SUM_W     = SQ_W + 2;
   localparam int SQRT_SH   = 12;
   localparam int SQRT_IN_W = SUM_W + SQRT_SH;
   localparam int ROOT_W    = SQRT_IN_W / 2;
   localparam int TRIAL_W   = SQRT_IN_W + 2;
   localparam int FRAC_W    = 14;
   localparam int NUM_SHIFT = FRAC_W + 6;
   localparam int NUM_W     = NORM_W + NUM_SHIFT + 1;
   localparam int DIV_CMP_W = NUM_W + 2;
   localparam int QUO_W     = 16;
   localparam int OUT_W     = 16;
   localparam logic [OUT_W-1:0] ONE = OUT_W'(1 << FRAC_W);

   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] az;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      logic signed [COORD_W-1:0] bz;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cz;
      logic                      has_three;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] nx;
      logic signed [OUT_W-1:0] ny;
      logic signed [OUT_W-1:0] nz;
      logic                    fell_back;
   } rsp_type;

   typedef struct packed {
      logic                      valid;
      logic                      fb;
      logic signed [CROSS_W-1:0] c0;
      logic signed [CROSS_W-1:0] c1;
      logic signed [CROSS_W-1:0] c2;
   } cross_type;

   typedef struct packed {
      logic              fb;
      logic [2:0]        neg;
      logic [NORM_W-1:0] m0;
      logic [NORM_W-1:0] m1;
      logic [NORM_W-1:0] m2;
   } side_type;

   typedef struct packed {
      logic             valid;
      side_type         side;
      logic [SUM_W-1:0] s;
   } sq_type;

   typedef struct packed {
      logic              valid;
      side_type          side;
      logic [ROOT_W-1:0] len;
   } len_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } res_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tfn_cross.sv =====
// ----------------------------------------------------------------------------
// tfn_cross: edge vectors and cross product
// Three stages: edge differences, six partial products, component subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_cross (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 adv,
   input  wire                 in_valid,
   input  tfn_pkg::req_type    in_req,
   output tfn_pkg::cross_type  out
);

   logic                              v1_ff, v2_ff, v3_ff;
   logic                              fb1_ff, fb2_ff, fb3_ff;
   logic signed [tfn_pkg::DIFF_W-1:0] u_ff [3];
   logic signed [tfn_pkg::DIFF_W-1:0] w_ff [3];
   logic signed [tfn_pkg::PROD_W-1:0] p_ff [6];
   logic signed [tfn_pkg::CROSS_W-1:0] c_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fb1_ff  <= ~in_req.has_three;
         u_ff[0] <= tfn_pkg::DIFF_W'(in_req.bx) - tfn_pkg::DIFF_W'(in_req.ax);
         u_ff[1] <= tfn_pkg::DIFF_W'(in_req.by) - tfn_pkg::DIFF_W'(in_req.ay);
         u_ff[2] <= tfn_pkg::DIFF_W'(in_req.bz) - tfn_pkg::DIFF_W'(in_req.az);
         w_ff[0] <= tfn_pkg::DIFF_W'(in_req.cx) - tfn_pkg::DIFF_W'(in_req.ax);
         w_ff[1] <= tfn_pkg::DIFF_W'(in_req.cy) - tfn_pkg::DIFF_W'(in_req.ay);
         w_ff[2] <= tfn_pkg::DIFF_W'(in_req.cz) - tfn_pkg::DIFF_W'(in_req.az);

         fb2_ff  <= fb1_ff;
         p_ff[0] <= tfn_pkg::PROD_W'(u_ff[1]) * tfn_pkg::PROD_W'(w_ff[2]);
         p_ff[1] <= tfn_pkg::PROD_W'(u_ff[2]) * tfn_pkg::PROD_W'(w_ff[1]);
         p_ff[2] <= tfn_pkg::PROD_W'(u_ff[2]) * tfn_pkg::PROD_W'(w_ff[0]);
         p_ff[3] <= tfn_pkg::PROD_W'(u_ff[0]) * tfn_pkg::PROD_W'(w_ff[2]);
         p_ff[4] <= tfn_pkg::PROD_W'(u_ff[0]) * tfn_pkg::PROD_W'(w_ff[1]);
         p_ff[5] <= tfn_pkg::PROD_W'(u_ff[1]) * tfn_pkg::PROD_W'(w_ff[0]);

         fb3_ff  <= fb2_ff;
         c_ff[0] <= tfn_pkg::CROSS_W'(p_ff[0]) - tfn_pkg::CROSS_W'(p_ff[1]);
         c_ff[1] <= tfn_pkg::CROSS_W'(p_ff[2]) - tfn_pkg::CROSS_W'(p_ff[3]);
         c_ff[2] <= tfn_pkg::CROSS_W'(p_ff[4]) - tfn_pkg::CROSS_W'(p_ff[5]);
      end
   end

   assign out.valid = v3_ff;
   assign out.fb    = fb3_ff;
   assign out.c0    = c_ff[0];
   assign out.c1    = c_ff[1];
   assign out.c2    = c_ff[2];

endmodule

`default_nettype wire

// ===== hw/rtl/tfn_norm.sv =====
// ----------------------------------------------------------------------------
// tfn_norm: magnitude normalization and sum of squares
// Four stages: magnitudes and leading-one position, block shift, squares, sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_norm (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 adv,
   input  tfn_pkg::cross_type  in,
   output tfn_pkg::sq_type     out
);

   logic [tfn_pkg::MAG_W-1:0]  mag_in [3];
   logic [tfn_pkg::MAG_W-1:0]  or_in;
   logic [tfn_pkg::POS_W-1:0]  pos_in;
   logic [tfn_pkg::MAG_W-1:0]  sh_full [3];

   logic                       v4_ff, v5_ff, v6_ff, v7_ff;
   logic                       fb4_ff;
   logic [2:0]                 neg4_ff;
   logic [tfn_pkg::MAG_W-1:0]  m4_ff [3];
   logic [tfn_pkg::POS_W-1:0]  pos4_ff;
   tfn_pkg::side_type          side5_ff, side6_ff, side7_ff;
   logic [tfn_pkg::SQ_W-1:0]   sq6_ff [3];
   logic [tfn_pkg::SUM_W-1:0]  sum7_ff;

   always_comb begin
      mag_in[0] = in.c0[tfn_pkg::CROSS_W-1] ? tfn_pkg::MAG_W'(-in.c0)
                                             : tfn_pkg::MAG_W'(in.c0);
      mag_in[1] = in.c1[tfn_pkg::CROSS_W-1] ? tfn_pkg::MAG_W'(-in.c1)
                                             : tfn_pkg::MAG_W'(in.c1);
      mag_in[2] = in.c2[tfn_pkg::CROSS_W-1] ? tfn_pkg::MAG_W'(-in.c2)
                                             : tfn_pkg::MAG_W'(in.c2);
      or_in  = mag_in[0] | mag_in[1] | mag_in[2];
      // leading one of the OR is the leading one of the largest magnitude
      pos_in = '0;
      for (int i = 0; i < tfn_pkg::MAG_W; i++) begin
         if (or_in[i]) pos_in = tfn_pkg::POS_W'(i);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (pos4_ff > tfn_pkg::POS_W'(tfn_pkg::NORM_MSB))
            sh_full[i] = m4_ff[i] >> (pos4_ff - tfn_pkg::POS_W'(tfn_pkg::NORM_MSB));
         else
            sh_full[i] = m4_ff[i] << (tfn_pkg::POS_W'(tfn_pkg::NORM_MSB) - pos4_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= in.valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fb4_ff  <= in.fb | (or_in == '0);
         neg4_ff <= {in.c2[tfn_pkg::CROSS_W-1], in.c1[tfn_pkg::CROSS_W-1],
                     in.c0[tfn_pkg::CROSS_W-1]};
         m4_ff   <= mag_in;
         pos4_ff <= pos_in;

         side5_ff.fb  <= fb4_ff;
         side5_ff.neg <= neg4_ff;
         side5_ff.m0  <= sh_full[0][tfn_pkg::NORM_W-1:0];
         side5_ff.m1  <= sh_full[1][tfn_pkg::NORM_W-1:0];
         side5_ff.m2  <= sh_full[2][tfn_pkg::NORM_W-1:0];

         side6_ff  <= side5_ff;
         sq6_ff[0] <= tfn_pkg::SQ_W'(side5_ff.m0) * tfn_pkg::SQ_W'(side5_ff.m0);
         sq6_ff[1] <= tfn_pkg::SQ_W'(side5_ff.m1) * tfn_pkg::SQ_W'(side5_ff.m1);
         sq6_ff[2] <= tfn_pkg::SQ_W'(side5_ff.m2) * tfn_pkg::SQ_W'(side5_ff.m2);

         side7_ff <= side6_ff;
         sum7_ff  <= tfn_pkg::SUM_W'(sq6_ff[0]) + tfn_pkg::SUM_W'(sq6_ff[1])
                     + tfn_pkg::SUM_W'(sq6_ff[2]);
      end
   end

   assign out.valid = v7_ff;
   assign out.side  = side7_ff;
   assign out.s     = sum7_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tfn_sqrt.sv =====
// ----------------------------------------------------------------------------
// tfn_sqrt: pipelined integer square root
// One root bit per stage, restoring method, of the scaled sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_sqrt (
   input  wire               clock,
   input  wire               reset,
   input  wire               adv,
   input  tfn_pkg::sq_type   in,
   output tfn_pkg::len_type  out
);

   localparam int N = tfn_pkg::ROOT_W;

   logic                           v_ff    [N];
   tfn_pkg::side_type              side_ff [N];
   logic [tfn_pkg::SQRT_IN_W-1:0]  rem_ff  [N];
   logic [tfn_pkg::ROOT_W-1:0]     root_ff [N];

   for (genvar j = 0; j < N; j++) begin : g_stage
      localparam int K = N - 1 - j;
      logic                           v_src;
      tfn_pkg::side_type              side_src;
      logic [tfn_pkg::SQRT_IN_W-1:0]  rem_src;
      logic [tfn_pkg::ROOT_W-1:0]     root_src;
      logic [tfn_pkg::TRIAL_W-1:0]    trial;
      logic                           take;

      if (j == 0) begin : g_first
         assign v_src    = in.valid;
         assign side_src = in.side;
         assign rem_src  = {in.s, tfn_pkg::SQRT_SH'(0)};
         assign root_src = '0;
      end else begin : g_next
         assign v_src    = v_ff[j-1];
         assign side_src = side_ff[j-1];
         assign rem_src  = rem_ff[j-1];
         assign root_src = root_ff[j-1];
      end

      // (R + 2^K)^2 <= x  <=>  x - R^2 >= (2R + 2^K) * 2^K
      assign trial = ((tfn_pkg::TRIAL_W'(root_src) << 1)
                      + (tfn_pkg::TRIAL_W'(1) << K)) << K;
      assign take  = tfn_pkg::TRIAL_W'(rem_src) >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (adv) begin
            v_ff[j] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[j] <= side_src;
            rem_ff[j]  <= take ? rem_src - tfn_pkg::SQRT_IN_W'(trial) : rem_src;
            root_ff[j] <= take ? root_src | (tfn_pkg::ROOT_W'(1) << K) : root_src;
         end
      end
   end

   assign out.valid = v_ff[N-1];
   assign out.side  = side_ff[N-1];
   assign out.len   = root_ff[N-1];

endmodule

`default_nettype wire

// ===== hw/rtl/tfn_div.sv =====
// ----------------------------------------------------------------------------
// tfn_div: rounded division of each component by the length, then packing
// Numerator stage, one quotient bit per stage on three lanes, output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_div (
   input  wire               clock,
   input  wire               reset,
   input  wire               adv,
   input  tfn_pkg::len_type  in,
   output tfn_pkg::res_type  out
);

   localparam int N = tfn_pkg::QUO_W;

   logic                          vp_ff;
   logic                          fbp_ff;
   logic [2:0]                    negp_ff;
   logic [tfn_pkg::ROOT_W-1:0]    lenp_ff;
   logic [tfn_pkg::NUM_W-1:0]     nump_ff [3];

   logic                          v_ff   [N];
   logic                          fb_ff  [N];
   logic [2:0]                    neg_ff [N];
   logic [tfn_pkg::ROOT_W-1:0]    len_ff [N];
   logic [tfn_pkg::NUM_W-1:0]     rem_ff [N][3];
   logic [tfn_pkg::QUO_W-1:0]     q_ff   [N][3];

   tfn_pkg::res_type              res_in, res_ff;
   logic [tfn_pkg::OUT_W-1:0]     qc     [3];
   logic [tfn_pkg::OUT_W-1:0]     sv     [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else if (adv) begin
         vp_ff <= in.valid;
      end
   end

   // numerator: m * 2^(F+6) + floor(len / 2)
   always_ff @(posedge clock) begin
      if (adv) begin
         fbp_ff     <= in.side.fb;
         negp_ff    <= in.side.neg;
         lenp_ff    <= in.len;
         nump_ff[0] <= (tfn_pkg::NUM_W'(in.side.m0) << tfn_pkg::NUM_SHIFT)
                       + tfn_pkg::NUM_W'(in.len >> 1);
         nump_ff[1] <= (tfn_pkg::NUM_W'(in.side.m1) << tfn_pkg::NUM_SHIFT)
                       + tfn_pkg::NUM_W'(in.len >> 1);
         nump_ff[2] <= (tfn_pkg::NUM_W'(in.side.m2) << tfn_pkg::NUM_SHIFT)
                       + tfn_pkg::NUM_W'(in.len >> 1);
      end
   end

   for (genvar j = 0; j < N; j++) begin : g_stage
      localparam int K = N - 1 - j;
      logic                          v_src, fb_src;
      logic [2:0]                    neg_src;
      logic [tfn_pkg::ROOT_W-1:0]    len_src;
      logic [tfn_pkg::DIV_CMP_W-1:0] dsh;

      if (j == 0) begin : g_first
         assign v_src   = vp_ff;
         assign fb_src  = fbp_ff;
         assign neg_src = negp_ff;
         assign len_src = lenp_ff;
      end else begin : g_next
         assign v_src   = v_ff[j-1];
         assign fb_src  = fb_ff[j-1];
         assign neg_src = neg_ff[j-1];
         assign len_src = len_ff[j-1];
      end

      assign dsh = tfn_pkg::DIV_CMP_W'(len_src) << K;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (adv) begin
            v_ff[j] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            fb_ff[j]  <= fb_src;
            neg_ff[j] <= neg_src;
            len_ff[j] <= len_src;
         end
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [tfn_pkg::NUM_W-1:0] rem_src;
         logic [tfn_pkg::QUO_W-1:0] q_src;
         logic                      take;

         if (j == 0) begin : g_first
            assign rem_src = nump_ff[l];
            assign q_src   = '0;
         end else begin : g_next
            assign rem_src = rem_ff[j-1][l];
            assign q_src   = q_ff[j-1][l];
         end

         assign take = tfn_pkg::DIV_CMP_W'(rem_src) >= dsh;

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[j][l] <= take ? rem_src - tfn_pkg::NUM_W'(dsh) : rem_src;
               q_ff[j][l]   <= take ? q_src | (tfn_pkg::QUO_W'(1) << K) : q_src;
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         qc[l] = (q_ff[N-1][l] > tfn_pkg::QUO_W'(tfn_pkg::ONE))
                 ? tfn_pkg::ONE : tfn_pkg::OUT_W'(q_ff[N-1][l]);
         sv[l] = neg_ff[N-1][l] ? -qc[l] : qc[l];
      end
      res_in.valid = v_ff[N-1];
      if (fb_ff[N-1]) begin
         res_in.data.nx        = '0;
         res_in.data.ny        = '0;
         res_in.data.nz        = tfn_pkg::ONE;
         res_in.data.fell_back = 1'b1;
      end else begin
         res_in.data.nx        = sv[0];
         res_in.data.ny        = sv[1];
         res_in.data.nz        = sv[2];
         res_in.data.fell_back = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else if (adv) begin
         res_ff.valid <= res_in.valid;
      end
      if (adv) begin
         res_ff.data <= res_in.data;
      end
   end

   assign out = res_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_face_normal_core.sv =====
// Throughput: one face per cycle; every stage advances together whenever the
// response register is empty or its transfer completes.
// Depth is set mostly by the 31-stage square root and the divider's 16 quotient-bit stages.
// Synchronous reset clears all valid bits; the pipeline is empty after reset.
// ----------------------------------------------------------------------------
// triangle_face_normal_core: unit face normal of a triangle, Q8.8 in, Q1.14 out
// Cross product, block normalization, square root and rounded division.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_face_normal_core (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  tfn_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output tfn_pkg::rsp_type  rsp_data
);

   logic                adv;
   tfn_pkg::cross_type  cross_w;
   tfn_pkg::sq_type     sq_w;
   tfn_pkg::len_type    len_w;
   tfn_pkg::res_type    res_w;

   // hold every stage while the response waits
   assign adv       = ~(rsp_valid & rsp_stall);
   assign req_stall = ~adv;

   tfn_cross u_cross (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .in_req   (req_data),
      .out      (cross_w)
   );

   tfn_norm u_norm (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .in    (cross_w),
      .out   (sq_w)
   );

   tfn_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .in    (sq_w),
      .out   (len_w)
   );

   tfn_div u_div (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .in    (len_w),
      .out   (res_w)
   );

   assign rsp_valid = res_w.valid;
   assign rsp_data  = res_w.data;

   a_stall_tracks_output: assert property (@(posedge clock)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow response backpressure");

   a_fallback_default: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fell_back |->
         rsp_data.nx == '0 && rsp_data.ny == '0 && rsp_data.nz == tfn_pkg::ONE)
      else $error("fallback response is not the default normal");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.fell_back |->
         rsp_data.nx <= $signed(tfn_pkg::ONE) && rsp_data.nx >= -$signed(tfn_pkg::ONE) &&
         rsp_data.ny <= $signed(tfn_pkg::ONE) && rsp_data.ny >= -$signed(tfn_pkg::ONE) &&
         rsp_data.nz <= $signed(tfn_pkg::ONE) && rsp_data.nz >= -$signed(tfn_pkg::ONE))
      else $error("normal component outside unit range");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(cross_w) && $stable(len_w))
      else $error("pipeline moved while stalled");

endmodule

`default_nettype wire
